@@ sv/positional_array_list_assert.svh @@
// Assertion macros for the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PAL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pal assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define PAL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pal assertion failed");

`endif

@@ sv/pal_pkg.sv @@
// Shared widths, sizes and codes for the positional array list.
package pal_pkg;

   // list sizing
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // channel field widths
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam func_type FN_GET    = 2'd0;
   localparam func_type FN_INSERT = 2'd1;
   localparam func_type FN_DELETE = 2'd2;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

@@ sv/pal_req_if.sv @@
// Request channel: operation, position and data word.
interface pal_req_if;
   logic                              valid;
   logic                              ready;
   pal_pkg::func_type                 func;
   logic [pal_pkg::POS_W-1:0]         position;
   logic [pal_pkg::VALUE_W-1:0]       item_value;

   modport source (output valid, func, position, item_value, input ready);
   modport sink   (input valid, func, position, item_value, output ready);
endinterface

@@ sv/pal_rsp_if.sv @@
// Response channel: status, read word and entry count.
interface pal_rsp_if;
   logic                              valid;
   logic                              ready;
   pal_pkg::status_type               status;
   logic [pal_pkg::VALUE_W-1:0]       read_value;
   logic [pal_pkg::COUNT_W-1:0]       count_after;

   modport source (output valid, status, read_value, count_after, input ready);
   modport sink   (input valid, status, read_value, count_after, output ready);
endinterface

@@ sv/positional_array_list.sv @@
// Top level of the positional array list: sequencer around one list memory.
//
// A fixed-capacity ordered list of words held in one synchronous RAM.
// req_ch carries one operation per transfer: get, insert or delete at a
// position. rsp_ch returns one transfer per request with the status
// (ok, out of range, full), the word read by a successful get (else zero)
// and the entry count after the operation.
// Get reads the word through S_READ; insert shifts the entries from the
// position up through S_INS, one per state, and writes the new word in
// S_PUT; delete shifts the entries above the position down through S_DEL.
// The RAM's one read and one write port move one entry per cycle.
// Rejected requests and appends go straight to S_DONE. One request is worked
// on at a time; req_ch.ready is high only while the sequencer is idle.
// The response sits in an output register; a stalled receiver holds it,
// and the block keeps taking and working one further request meanwhile.
// Reset (synchronous) empties the list and drops any pending response;
// no clearing pass is needed since only entries below the count are read.
`include "positional_array_list_assert.svh"

module positional_array_list (
   input  logic          clock,
   input  logic          reset,
   pal_req_if.sink       req_ch,
   pal_rsp_if.source     rsp_ch
);

   localparam int DW     = pal_pkg::DATA_WIDTH;
   localparam int AW     = pal_pkg::ADDR_W;
   localparam int CW     = pal_pkg::CNT_W;
   localparam int VW     = pal_pkg::VALUE_W;
   localparam int CMP_W  = (pal_pkg::POS_W > CW) ? pal_pkg::POS_W + 1 : CW + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_PUT  = 3'd3;
   localparam logic [2:0] S_DEL  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [DW-1:0]        word_ff, word_in;
   pal_pkg::status_type  status_ff, status_in;
   logic [VW-1:0]        value_ff, value_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pal_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic [pal_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // list memory ports
   logic [DW-1:0]        mem [pal_pkg::CAPACITY];
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [DW-1:0]        wr_data, rd_q_ff;

   logic                 req_xfer, rsp_free;
   logic [CMP_W-1:0]     pos_w, cnt_w;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign pos_w    = CMP_W'(req_ch.position);
   assign cnt_w    = CMP_W'(count_ff);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.count_after = rsp_count_ff;

   // Sequencer. Shifts read one entry and write the previously read one
   // each cycle; the read address always runs two entries ahead of the
   // write address, so the ports never touch the same entry.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      word_in   = word_ff;
      status_in = status_ff;
      value_in  = value_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               pos_in    = AW'(req_ch.position);
               word_in   = DW'(req_ch.item_value);
               value_in  = '0;
               status_in = pal_pkg::ST_RANGE;
               state_in  = S_DONE;
               unique case (req_ch.func)
                  pal_pkg::FN_GET: begin
                     if (pos_w < cnt_w) begin
                        rd_en     = 1'b1;
                        rd_addr   = AW'(req_ch.position);
                        status_in = pal_pkg::ST_OK;
                        state_in  = S_READ;
                     end
                  end
                  pal_pkg::FN_INSERT: begin
                     if (pos_w > cnt_w) begin
                        status_in = pal_pkg::ST_RANGE;
                     end else if (count_ff == CW'(pal_pkg::CAPACITY)) begin
                        status_in = pal_pkg::ST_FULL;
                     end else begin
                        status_in = pal_pkg::ST_OK;
                        count_in  = count_ff + 1'b1;
                        if (pos_w == cnt_w) begin
                           // append: no shift needed
                           wr_en   = 1'b1;
                           wr_addr = AW'(req_ch.position);
                           wr_data = DW'(req_ch.item_value);
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = AW'(count_ff - 1'b1);
                           idx_in   = AW'(count_ff);
                           state_in = S_INS;
                        end
                     end
                  end
                  pal_pkg::FN_DELETE: begin
                     if (pos_w < cnt_w) begin
                        status_in = pal_pkg::ST_OK;
                        count_in  = count_ff - 1'b1;
                        if (pos_w + 1'b1 < cnt_w) begin
                           rd_en    = 1'b1;
                           rd_addr  = AW'(pos_w + 1'b1);
                           idx_in   = AW'(req_ch.position);
                           state_in = S_DEL;
                        end
                     end
                  end
                  default: begin
                     status_in = pal_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         S_READ: begin
            value_in = VW'(rd_q_ff);
            state_in = S_DONE;
         end
         S_INS: begin
            // move entry idx-1 up to idx; fetch the next one down
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if ({1'b0, idx_ff} > ({1'b0, pos_ff} + 1'b1)) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - AW'(2);
               idx_in  = idx_ff - 1'b1;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = word_ff;
            state_in = S_DONE;
         end
         S_DEL: begin
            // move entry idx+1 down to idx; count already holds the new value
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if ((CW + 1)'(idx_ff) + 1'b1 < (CW + 1)'(count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = AW'((CW + 1)'(idx_ff) + 2'd2);
               idx_in  = idx_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = value_ff;
               rsp_count_in  = pal_pkg::COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // list memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // checks
   `PAL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(pal_pkg::CAPACITY))
   `PAL_ASSERT_NOW(a_port_apart, rd_en && wr_en, rd_addr != wr_addr)
   `PAL_ASSERT_NEXT(a_busy_after_req, req_xfer, state_ff != S_IDLE)
   `PAL_ASSERT_NEXT(a_hold_done, state_ff == S_DONE && !rsp_free,
                    state_ff == S_DONE && rsp_valid_ff)

endmodule
